// ===== design/clp_pkg.sv =====
// Shared types, character codes and command tables for the command line parser.
package clp_pkg;

	localparam int unsigned LINE_BYTES_DEF = 64;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned CODE_W         = 24;
	localparam int unsigned VALUE_W        = 10;
	localparam int unsigned ACC_W          = 14;

	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
	localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

	localparam logic [VALUE_W-1:0] VALUE_SAT   = 10'd1023;
	localparam logic [VALUE_W-1:0] LIMIT_MODE  = 10'd4;
	localparam logic [VALUE_W-1:0] LIMIT_ROLL  = 10'd2;
	localparam logic [VALUE_W-1:0] LIMIT_LEVEL = 10'd1000;
	localparam logic [VALUE_W-1:0] RESET_VALUE = 10'd1;

	localparam logic [CODE_W-1:0] CODE_MOD = 24'h4D4F44;
	localparam logic [CODE_W-1:0] CODE_RST = 24'h525354;
	localparam logic [CODE_W-1:0] CODE_ROL = 24'h524F4C;
	localparam logic [CODE_W-1:0] CODE_BRT = 24'h425254;
	localparam logic [CODE_W-1:0] CODE_RED = 24'h524544;
	localparam logic [CODE_W-1:0] CODE_GRN = 24'h47524E;
	localparam logic [CODE_W-1:0] CODE_BLU = 24'h424C55;
	localparam logic [CODE_W-1:0] CODE_UVV = 24'h555656;
	localparam logic [CODE_W-1:0] CODE_WHT = 24'h574854;
	localparam logic [CODE_W-1:0] CODE_SYN = 24'h53594E;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_FORMAT = 2'd1,
		STATUS_VALUE  = 2'd2
	} status_t;

	// Per-line facts that decide the status of a finished line.
	typedef struct packed {
		logic                lead_ok;
		logic                value_seen;
		logic                colon_ok;
		logic                digits_bad;
		logic [CODE_W-1:0]   code;
		logic [VALUE_W-1:0]  value;
	} line_info_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} result_t;

	function automatic logic is_level_code(input logic [CODE_W-1:0] c);
		return (c == CODE_BRT) || (c == CODE_RED) || (c == CODE_GRN) ||
			(c == CODE_BLU) || (c == CODE_UVV) || (c == CODE_WHT) ||
			(c == CODE_SYN);
	endfunction

endpackage

// ===== design/clp_judge.sv =====
// Status decision for a completed command line.
module clp_judge import clp_pkg::*; (
	input  line_info_t info,
	output status_t    status
);

	always_comb begin
		if (!info.lead_ok || !info.value_seen || !info.colon_ok) begin
			status = STATUS_FORMAT;
		end else if (info.digits_bad) begin
			status = STATUS_VALUE;
		end else if (info.code == CODE_MOD) begin
			status = (info.value > LIMIT_MODE) ? STATUS_VALUE : STATUS_OK;
		end else if (info.code == CODE_RST) begin
			status = (info.value == RESET_VALUE) ? STATUS_OK : STATUS_VALUE;
		end else if (info.code == CODE_ROL) begin
			status = (info.value > LIMIT_ROLL) ? STATUS_VALUE : STATUS_OK;
		end else if (is_level_code(info.code)) begin
			status = (info.value > LIMIT_LEVEL) ? STATUS_VALUE : STATUS_OK;
		end else begin
			status = STATUS_FORMAT;
		end
	end

endmodule

// ===== design/clp_line_tracker.sv =====
// Per-line state of the parser, updated once for each received byte other than a carriage return.
module clp_line_tracker import clp_pkg::*; #(
	parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [BYTE_W-1:0] rx_byte,
	output result_t           res
);

	localparam int unsigned CNT_W = $clog2(LINE_BYTES);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_BYTES - 1);

	logic [CNT_W-1:0]   char_count_q;
	logic               too_long_q;
	logic               content_ended_q;
	logic               lead_ok_q;
	logic               colon_ok_q;
	logic [CODE_W-1:0]  code_chars_q;
	logic               digits_bad_q;
	logic [VALUE_W-1:0] value_acc_q;
	logic               value_seen_q;

	line_info_t         info;
	status_t            judged;
	logic               is_cr;
	logic               is_lf;
	logic               is_digit;
	logic [ACC_W-1:0]   acc_next;
	logic [VALUE_W-1:0] acc_sat;

	assign is_cr    = (rx_byte == CHAR_CR);
	assign is_lf    = (rx_byte == CHAR_LF);
	assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);

	// value * 10 + digit, clamped to the 10-bit ceiling
	assign acc_next = {1'b0, value_acc_q, 3'b000} + {3'b000, value_acc_q, 1'b0}
		+ ACC_W'(rx_byte - CHAR_ZERO);
	assign acc_sat  = (acc_next > ACC_W'(VALUE_SAT)) ? VALUE_SAT : acc_next[VALUE_W-1:0];

	assign info = '{
		lead_ok:    lead_ok_q,
		value_seen: value_seen_q,
		colon_ok:   colon_ok_q,
		digits_bad: digits_bad_q,
		code:       code_chars_q,
		value:      value_acc_q
	};

	clp_judge u_judge (
		.info   (info),
		.status (judged)
	);

	always_comb begin
		res.valid  = en && is_lf && (too_long_q || (char_count_q != '0));
		res.status = too_long_q ? STATUS_VALUE : judged;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q    <= '0;
			too_long_q      <= 1'b0;
			content_ended_q <= 1'b0;
			lead_ok_q       <= 1'b0;
			colon_ok_q      <= 1'b0;
			code_chars_q    <= '0;
			digits_bad_q    <= 1'b0;
			value_acc_q     <= '0;
			value_seen_q    <= 1'b0;
		end else if (en && !is_cr) begin
			if (is_lf) begin
				char_count_q    <= '0;
				too_long_q      <= 1'b0;
				content_ended_q <= 1'b0;
				lead_ok_q       <= 1'b0;
				colon_ok_q      <= 1'b0;
				code_chars_q    <= '0;
				digits_bad_q    <= 1'b0;
				value_acc_q     <= '0;
				value_seen_q    <= 1'b0;
			end else if (char_count_q == CNT_FULL) begin
				too_long_q <= 1'b1;
			end else begin
				char_count_q <= char_count_q + CNT_W'(1);
				// A zero byte ends the content; later bytes only count.
				if (content_ended_q || (rx_byte == CHAR_NUL)) begin
					content_ended_q <= 1'b1;
				end else if (char_count_q == CNT_W'(0)) begin
					lead_ok_q <= (rx_byte == CHAR_E);
				end else if (char_count_q <= CNT_W'(3)) begin
					code_chars_q <= {code_chars_q[CODE_W-BYTE_W-1:0], rx_byte};
				end else if (char_count_q == CNT_W'(4)) begin
					colon_ok_q <= (rx_byte == CHAR_COLON);
				end else begin
					value_seen_q <= 1'b1;
					if (!is_digit) begin
						digits_bad_q <= 1'b1;
					end else begin
						value_acc_q <= acc_sat;
					end
				end
			end
		end
	end

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		too_long_q |-> (char_count_q == CNT_FULL))
		else $error("overflow flag set while line not full");

	a_ended_counted: assert property (@(posedge clk) disable iff (!arst_n)
		content_ended_q |-> (char_count_q != '0))
		else $error("content end marked on an empty line");

	a_lf_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(en && is_lf) |=> (char_count_q == '0) && !too_long_q && !value_seen_q)
		else $error("line feed did not clear the line state");

endmodule

// ===== design/command_line_parser.sv =====
// Command line parser: takes one byte per cycle on the input stream, while the
// input register is free or can advance, and gives one status request per nonempty
// line on the output stream. Every byte, including a line feed, passes through the
// input register; a line's status is loaded into the result register when the line
// feed advances out of the input register, and the input keeps flowing while a
// finished status waits as long as the result register is free or being drained in
// the same cycle.
module command_line_parser import clp_pkg::*; #(
	parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [1:0] status, [7:2] zero
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	status_t           status_q;
	logic              advance;
	result_t           res;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, status_q};

	clp_line_tracker #(
		.LINE_BYTES (LINE_BYTES)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1 && advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.valid) begin
			status_q <= res.status;
		end
	end

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status_q == STATUS_OK || status_q == STATUS_FORMAT ||
			status_q == STATUS_VALUE))
		else $error("status code out of range");

	a_result_from_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && res.valid) |-> (byte_s1 == CHAR_LF))
		else $error("result raised by a byte other than line feed");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input stage lost a byte while stalled");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for command_line_parser: directed lines, then checked random lines.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import clp_pkg::*;

	localparam int WANT_PREDICT   = -1;
	localparam int RANDOM_BYTES   = 1100;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [7:0] NUL_MARK = "~";

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       m_tready = 1'b0;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;

	// Predicted status of each finished line, oldest first.
	status_t exp_status[$];
	int      fail_count  = 0;
	int      sent_count  = 0;
	int      idle_cycles = 0;
	int      hold_req    = 0;
	bit      quiet       = 1'b0;

	// Line state of the predictor.
	int                 line_len;
	bit                 overflow;
	bit                 nul_seen;
	bit                 lead_seen;
	bit                 colon_seen;
	bit                 value_seen;
	bit                 bad_digit;
	logic [CODE_W-1:0]  code_acc;
	logic [VALUE_W-1:0] value_acc;

	string      dir_text[$];
	int         dir_want[$];
	logic [7:0] line_bytes[$];

	always #2 clk = ~clk;

	command_line_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	task automatic clear_line_state();
		line_len   = 0;
		overflow   = 1'b0;
		nul_seen   = 1'b0;
		lead_seen  = 1'b0;
		colon_seen = 1'b0;
		value_seen = 1'b0;
		bad_digit  = 1'b0;
		code_acc   = '0;
		value_acc  = '0;
	endtask

	task automatic predict_byte(input logic [7:0] b, output bit has_status, output status_t st);
		int                 pos;
		logic [ACC_W-1:0]   sum;
		logic [VALUE_W-1:0] limit;
		has_status = 1'b0;
		st = STATUS_OK;
		if (b == CHAR_CR)
			return;
		if (b == CHAR_LF) begin
			if (overflow) begin
				has_status = 1'b1;
				st = STATUS_VALUE;
			end else if (line_len != 0) begin
				has_status = 1'b1;
				limit = LIMIT_LEVEL;
				if (!lead_seen || !value_seen || !colon_seen)
					st = STATUS_FORMAT;
				else if (bad_digit)
					st = STATUS_VALUE;
				else begin
					case (code_acc)
						CODE_MOD: limit = LIMIT_MODE;
						CODE_ROL: limit = LIMIT_ROLL;
						CODE_RST: limit = RESET_VALUE;
						CODE_BRT, CODE_RED, CODE_GRN, CODE_BLU,
						CODE_UVV, CODE_WHT, CODE_SYN: limit = LIMIT_LEVEL;
						default: st = STATUS_FORMAT;
					endcase
					// A reset command needs exactly its one value, not a range.
					if (st != STATUS_FORMAT) begin
						if (code_acc == CODE_RST)
							st = (value_acc == RESET_VALUE) ? STATUS_OK : STATUS_VALUE;
						else
							st = (value_acc > limit) ? STATUS_VALUE : STATUS_OK;
					end
				end
			end
			clear_line_state();
			return;
		end
		if (line_len >= LINE_BYTES_DEF - 1) begin
			overflow = 1'b1;
			return;
		end
		pos = line_len;
		line_len++;
		// Once a zero byte is seen, the rest of the line only counts toward its length.
		if (nul_seen || b == CHAR_NUL) begin
			nul_seen = 1'b1;
			return;
		end
		if (pos == 0)
			lead_seen = (b == CHAR_E);
		else if (pos <= 3)
			code_acc = {code_acc[CODE_W-9:0], b};
		else if (pos == 4)
			colon_seen = (b == CHAR_COLON);
		else begin
			value_seen = 1'b1;
			if (b < CHAR_ZERO || b > CHAR_NINE)
				bad_digit = 1'b1;
			else begin
				sum = ACC_W'(value_acc * 10 + (b - CHAR_ZERO));
				value_acc = (sum > VALUE_SAT) ? VALUE_SAT : sum[VALUE_W-1:0];
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// Called at a rising edge; returns at the edge where the byte request is accepted.
	task automatic send_byte(input logic [7:0] b, input int gap, input int want);
		bit      has_status;
		status_t st;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_byte(b, has_status, st);
		if (has_status)
			exp_status.push_back((want == WANT_PREDICT) ? st : status_t'(want));
		if (b != CHAR_CR)
			sent_count++;
	endtask

	task automatic send_text(input string s, input int want);
		logic [7:0] b;
		for (int i = 0; i < s.len(); i++) begin
			b = s[i];
			if (b == NUL_MARK)
				b = CHAR_NUL;
			send_byte(b, pick_gap(), want);
		end
	endtask

	task automatic add_row(input string s, input int want);
		dir_text.push_back(s);
		dir_want.push_back(want);
	endtask

	// Builds one random line: mostly well-formed commands, some broken, some overlong, some empty, some noise.
	task automatic make_line();
		int                kind;
		int                n;
		int                r;
		int                v;
		string             digits;
		logic [CODE_W-1:0] code;
		line_bytes = {};
		kind = $urandom_range(99);
		if (kind < 12) begin
			n = $urandom_range(1, 12);
			repeat (n) line_bytes.push_back(8'($urandom_range(255)));
		end else if (kind < 15) begin
			n = $urandom_range(58, 75);
			code = CODE_SYN;
			line_bytes = {CHAR_E, code[23:16], code[15:8], code[7:0], CHAR_COLON};
			repeat (n - 5) line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
		end else if (kind >= 18) begin
			case ($urandom_range(11))
				0: code = CODE_MOD;
				1: code = CODE_RST;
				2: code = CODE_ROL;
				3: code = CODE_BRT;
				4: code = CODE_RED;
				5: code = CODE_GRN;
				6: code = CODE_BLU;
				7: code = CODE_UVV;
				8: code = CODE_WHT;
				9: code = CODE_SYN;
				default: code = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
					8'($urandom_range(65, 90))};
			endcase
			r = $urandom_range(99);
			if (r < 40)
				v = $urandom_range(5);
			else if (r < 70)
				v = $urandom_range(1100);
			else if (r < 85)
				v = $urandom_range(995, 1030);
			else
				v = $urandom_range(99999);
			digits = $sformatf("%0d", v);
			if ($urandom_range(9) == 0)
				digits = {"00", digits};
			line_bytes = {CHAR_E, code[23:16], code[15:8], code[7:0], CHAR_COLON};
			for (int i = 0; i < digits.len(); i++)
				line_bytes.push_back(digits[i]);
			if (kind >= 88)
				line_bytes[$urandom_range(line_bytes.size() - 1)] =
					($urandom_range(3) == 0) ? CHAR_NUL : 8'($urandom_range(255));
		end
		line_bytes.push_back(CHAR_LF);
		if ($urandom_range(19) == 0)
			line_bytes.insert($urandom_range(line_bytes.size() - 1), CHAR_CR);
	endtask

	// Receiver: random stalls, with one long hold when the stimulus asks for it.
	initial begin
		int stall_left;
		int holds_done;
		int r;
		stall_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				holds_done = hold_req;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(99);
				if (r < 70)
					m_tready <= 1'b1;
				else begin
					m_tready <= 1'b0;
					stall_left = (r < 95) ? $urandom_range(3) : $urandom_range(20, 80);
				end
			end
		end
	end

	always @(posedge clk) begin
		status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_status.size() == 0) begin
				$display("%0t ns: status request with none expected, got %0d", $time, m_tdata);
				fail_count++;
			end else begin
				want = exp_status.pop_front();
				if (m_tdata[1:0] != want) begin
					$display("%0t ns: status expected %0d (%s), actual %0d", $time, want,
						want.name(), m_tdata[1:0]);
					fail_count++;
				end
				if (m_tdata[7:2] != 6'd0) begin
					$display("%0t ns: status pad bits expected 0, actual %0h", $time,
						m_tdata[7:2]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no request accepted for %0d cycles", $time, idle_cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		string long_ok;
		string long_bad;
		int    dir_bytes;
		bit    hold_done;
		bit    pause_done;
		hold_done = 1'b0;
		pause_done = 1'b0;
		clear_line_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		long_ok = "ESYN:";
		repeat (57) long_ok = {long_ok, "0"};
		long_ok = {long_ok, "7\n"};
		long_bad = "EBRT:";
		repeat (60) long_bad = {long_bad, "1"};
		long_bad = {long_bad, "\n"};

		// A tilde in these lines stands for a zero byte.
		add_row("EMOD:0\n", STATUS_OK);
		add_row("EMOD:4\n", STATUS_OK);
		add_row("EMOD:5\n", STATUS_VALUE);
		add_row("ERST:1\n", STATUS_OK);
		add_row("ERST:0\n", STATUS_VALUE);
		add_row("EROL:2\n", STATUS_OK);
		add_row("EROL:3\n", STATUS_VALUE);
		add_row("EBRT:1000\n", STATUS_OK);
		add_row("ERED:1001\n", STATUS_VALUE);
		add_row("EGRN:0\n", STATUS_OK);
		add_row("EBLU:7\n", STATUS_OK);
		add_row("EUVV:999\n", STATUS_OK);
		add_row("EWHT:500\n", STATUS_OK);
		add_row("ESYN:99999\n", STATUS_VALUE);
		add_row("EXYZ:1\n", STATUS_FORMAT);
		add_row("XMOD:1\n", STATUS_FORMAT);
		add_row("EMOD:\n", STATUS_FORMAT);
		add_row("EMOD;1\n", STATUS_FORMAT);
		add_row("EXYZ:1a\n", STATUS_VALUE);
		add_row("~EMOD:1\n", STATUS_FORMAT);
		add_row("EMOD:1~9\n", WANT_PREDICT);
		add_row("\n", WANT_PREDICT);
		add_row("\r\nEMOD:\r2\r\n", WANT_PREDICT);
		add_row(long_ok, WANT_PREDICT);
		add_row(long_bad, STATUS_VALUE);
		foreach (dir_text[i])
			send_text(dir_text[i], dir_want[i]);
		dir_bytes = sent_count;

		while (sent_count < dir_bytes + RANDOM_BYTES) begin
			quiet = ($urandom_range(9) == 0);
			if (!hold_done && sent_count > dir_bytes + 400) begin
				// Keep offering lines through a long receiver hold so the input backs up.
				hold_done = 1'b1;
				quiet = 1'b1;
				hold_req++;
				repeat (12) send_text("ERED:5\n", WANT_PREDICT);
				quiet = 1'b0;
			end
			if (!pause_done && sent_count > dir_bytes + 900) begin
				pause_done = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (exp_status.size() != 0);
			end
			make_line();
			foreach (line_bytes[i])
				send_byte(line_bytes[i], pick_gap(), WANT_PREDICT);
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		while (exp_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/clp_pkg.sv
design/clp_judge.sv
design/clp_line_tracker.sv
design/command_line_parser.sv
verif/tb_top.sv
